// File: hdl/mvma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh volume moment accumulator package
// Shared widths, sum indexes, pair tables and payload types.
// ----------------------------------------------------------------------------
package mvma_pkg;

  localparam int FIELD_W        = 10;
  localparam int COORD_BITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ACC_W          = 64;
  localparam int NUM_SUMS       = 10;
  localparam int NUM_AXES       = 3;

  localparam int IDX_VOL   = 0;
  localparam int IDX_FIRST = 1;
  localparam int IDX_DIAG  = 4;
  localparam int IDX_OFF   = 7;

  localparam logic [1:0] PAIR_A [3] = '{2'd0, 2'd0, 2'd1};
  localparam logic [1:0] PAIR_B [3] = '{2'd1, 2'd2, 2'd2};

  typedef logic [2:0][2:0][FIELD_W-1:0] face_t;
  typedef logic [NUM_SUMS-1:0][ACC_W-1:0] res_t;

  function automatic int d_w(input int cw);
    return 3 * cw + 1;
  endfunction

  function automatic int s_w(input int cw);
    return cw + 2;
  endfunction

  function automatic int q_w(input int cw);
    return 2 * cw + 2;
  endfunction

  function automatic int t_w(input int cw);
    return 2 * cw + 3;
  endfunction

  function automatic int entry_w(input int cw);
    return d_w(cw) + 3 * (d_w(cw) + s_w(cw)) + 3 * (d_w(cw) + q_w(cw))
         + 3 * (d_w(cw) + t_w(cw)) + 1;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mvma_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle term pipeline
// Five register stages turn one triangle into its determinant and the nine
// weighted moment terms, then the final products feed the queue.
// ----------------------------------------------------------------------------
module mvma_front #(
  parameter int COORD_BITS = mvma_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      item_vld,
  input  mvma_pkg::face_t                           item_face,
  input  logic                                      item_last,
  output logic                                      push,
  output logic [mvma_pkg::entry_w(COORD_BITS)-1:0]  push_data
);
  import mvma_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int PW  = 2 * CW;
  localparam int MW  = 2 * CW + 1;
  localparam int SW  = s_w(CW);
  localparam int QW  = q_w(CW);
  localparam int TW  = t_w(CW);
  localparam int DW  = d_w(CW);
  localparam int SPW = DW + SW;
  localparam int QPW = DW + QW;
  localparam int TPW = DW + TW;

  logic [4:0] vld_r;
  logic [4:0] last_r;

  logic signed [CW-1:0] p1_r [3][3];

  logic signed [PW-1:0] mpa2_r [3];
  logic signed [PW-1:0] mpb2_r [3];
  logic signed [PW-1:0] sq2_r  [3][3];
  logic signed [PW-1:0] cr2_r  [3][3];
  logic signed [PW-1:0] of2_r  [3][3];
  logic signed [SW-1:0] s2_r   [3];
  logic signed [CW-1:0] p02_r  [3];

  logic signed [MW-1:0] mn3_r [3];
  logic signed [QW-1:0] q3_r  [3];
  logic signed [TW-1:0] tp3_r [3];
  logic signed [TW-1:0] ss3_r [3];
  logic signed [SW-1:0] s3_r  [3];
  logic signed [CW-1:0] p03_r [3];

  logic signed [DW-1:0] dt4_r [3];
  logic signed [TW-1:0] t4_r  [3];
  logic signed [QW-1:0] q4_r  [3];
  logic signed [SW-1:0] s4_r  [3];

  logic signed [DW-1:0] d5_r;
  logic signed [TW-1:0] t5_r [3];
  logic signed [QW-1:0] q5_r [3];
  logic signed [SW-1:0] s5_r [3];

  logic signed [SPW-1:0] ds [3];
  logic signed [QPW-1:0] dq [3];
  logic signed [TPW-1:0] dt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], item_vld};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[3:0], item_last};
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p1_r[i][k] <= item_face[i][k][CW-1:0];
      end
    end

    for (int k = 0; k < 3; k++) begin
      mpa2_r[k] <= PW'(p1_r[1][PAIR_A[2-k]]) * PW'(p1_r[2][PAIR_B[2-k]]);
      mpb2_r[k] <= PW'(p1_r[1][PAIR_B[2-k]]) * PW'(p1_r[2][PAIR_A[2-k]]);
      s2_r[k]   <= SW'(p1_r[0][k]) + SW'(p1_r[1][k]) + SW'(p1_r[2][k]);
      p02_r[k]  <= p1_r[0][k];
      for (int i = 0; i < 3; i++) begin
        sq2_r[k][i] <= PW'(p1_r[i][k]) * PW'(p1_r[i][k]);
        cr2_r[k][i] <= PW'(p1_r[PAIR_A[i]][k]) * PW'(p1_r[PAIR_B[i]][k]);
        of2_r[k][i] <= PW'(p1_r[i][PAIR_A[k]]) * PW'(p1_r[i][PAIR_B[k]]);
      end
    end

    for (int k = 0; k < 3; k++) begin
      mn3_r[k] <= MW'(mpa2_r[k]) - MW'(mpb2_r[k]);
      q3_r[k]  <= QW'(sq2_r[k][0]) + QW'(sq2_r[k][1]) + QW'(sq2_r[k][2])
                + QW'(cr2_r[k][0]) + QW'(cr2_r[k][1]) + QW'(cr2_r[k][2]);
      tp3_r[k] <= TW'(of2_r[k][0]) + TW'(of2_r[k][1]) + TW'(of2_r[k][2]);
      ss3_r[k] <= TW'(s2_r[PAIR_A[k]]) * TW'(s2_r[PAIR_B[k]]);
      s3_r[k]  <= s2_r[k];
      p03_r[k] <= p02_r[k];
    end

    for (int k = 0; k < 3; k++) begin
      dt4_r[k] <= DW'(p03_r[k]) * DW'(mn3_r[k]);
      t4_r[k]  <= tp3_r[k] + ss3_r[k];
      q4_r[k]  <= q3_r[k];
      s4_r[k]  <= s3_r[k];
    end

    d5_r <= dt4_r[0] - dt4_r[1] + dt4_r[2];
    for (int k = 0; k < 3; k++) begin
      t5_r[k] <= t4_r[k];
      q5_r[k] <= q4_r[k];
      s5_r[k] <= s4_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ds[k] = SPW'(d5_r) * SPW'(s5_r[k]);
      dq[k] = QPW'(d5_r) * QPW'(q5_r[k]);
      dt[k] = TPW'(d5_r) * TPW'(t5_r[k]);
    end
  end

  assign push      = vld_r[4];
  assign push_data = {last_r[4], dt[2], dt[1], dt[0], dq[2], dq[1], dq[0],
                      ds[2], ds[1], ds[0], d5_r};

endmodule
`default_nettype wire

// File: hdl/mvma_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Term queue
// Small register FIFO between the term pipeline and the accumulators.
// ----------------------------------------------------------------------------
module mvma_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mvma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import mvma_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [NW-1:0]    count_r;
  logic [AW-1:0]    wptr_nxt;
  logic [AW-1:0]    rptr_nxt;

  assign wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wptr_nxt;
      end
      if (rd_en) begin
        rptr_r <= rptr_nxt;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rptr_r];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && !rd_en && count_r == NW'(DEPTH)))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && count_r == '0))
    else $error("Queue read while empty.");
`endif

endmodule
`default_nettype wire

// File: hdl/mvma_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating accumulators
// Adds one queued set of terms per cycle into ten 64-bit sums unless a held
// result stalls a mesh's last triangle, which loads the result register.
// ----------------------------------------------------------------------------
module mvma_back #(
  parameter int COORD_BITS = mvma_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_valid,
  input  logic [mvma_pkg::entry_w(COORD_BITS)-1:0]  q_data,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output mvma_pkg::res_t                            out_res
);
  import mvma_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = d_w(CW);
  localparam int SPW   = DW + s_w(CW);
  localparam int QPW   = DW + q_w(CW);
  localparam int TPW   = DW + t_w(CW);
  localparam int EW    = entry_w(CW);
  localparam int OFF_S = DW;
  localparam int OFF_Q = OFF_S + 3 * SPW;
  localparam int OFF_T = OFF_Q + 3 * QPW;

  res_t acc_r;
  res_t out_r;
  res_t term;
  res_t sum;
  logic out_valid_r;
  logic q_last;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] wide;
    wide = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      return {wide[ACC_W], {(ACC_W - 1){~wide[ACC_W]}}};
    end
    return wide[ACC_W-1:0];
  endfunction

  always_comb begin
    term[IDX_VOL] = ACC_W'($signed(q_data[DW-1:0]));
    for (int k = 0; k < NUM_AXES; k++) begin
      term[IDX_FIRST + k] = ACC_W'($signed(q_data[OFF_S + k * SPW +: SPW]));
      term[IDX_DIAG + k]  = ACC_W'($signed(q_data[OFF_Q + k * QPW +: QPW]));
      term[IDX_OFF + k]   = ACC_W'($signed(q_data[OFF_T + k * TPW +: TPW]));
    end
    for (int j = 0; j < NUM_SUMS; j++) begin
      sum[j] = sat_add(acc_r[j], term[j]);
    end
  end

  assign q_last = q_data[EW-1];
  assign q_pop  = q_valid && (!q_last || !out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_last) begin
          acc_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_last) begin
      out_r <= sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_last) |=> (acc_r == '0))
    else $error("Sums not cleared after the last triangle.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(q_pop && q_last))
    else $error("Result raised without a last triangle.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_last && out_valid_r && out_stall))
    else $error("Held result overwritten.");
`endif

endmodule
`default_nettype wire

// File: hdl/mesh_volume_moment_accumulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh volume and moment accumulator
// Sums the signed-tetrahedron volume, first and second moment numerators of
// a closed triangle mesh and presents them on the mesh's last triangle.
// ----------------------------------------------------------------------------
// The result of a mesh follows its last triangle through the term pipeline,
// the queue and the result register. Throughput: one triangle per cycle
// while in_stall is low, bounded by the saturating add into the sums; the term
// pipeline and the QUEUE_DEPTH-entry queue hold at most QUEUE_DEPTH items.
// Reset is synchronous and clears the sums, the queue and all valid state.
module mesh_volume_moment_accumulator_top #(
  parameter int COORD_BITS  = mvma_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = mvma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v0_x,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v0_y,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v0_z,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v1_x,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v1_y,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v1_z,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v2_x,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v2_y,
  input  logic signed [mvma_pkg::FIELD_W-1:0]  in_v2_z,
  input  logic                                 in_last_triangle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_vol_six,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_first_x,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_first_y,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_first_z,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_xx,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_yy,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_zz,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_xy,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_xz,
  output logic signed [mvma_pkg::ACC_W-1:0]    out_second_yz
);
  import mvma_pkg::*;

  localparam int EW = entry_w(COORD_BITS);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  face_t         face_w;
  logic          accept;
  logic          push;
  logic [EW-1:0] push_data;
  logic          q_valid;
  logic [EW-1:0] q_data;
  logic          q_pop;
  res_t          res_w;
  logic [OW-1:0] occ_r;
  logic [OW-1:0] occ_nxt;

  assign face_w[0][0] = in_v0_x;
  assign face_w[0][1] = in_v0_y;
  assign face_w[0][2] = in_v0_z;
  assign face_w[1][0] = in_v1_x;
  assign face_w[1][1] = in_v1_y;
  assign face_w[1][2] = in_v1_z;
  assign face_w[2][0] = in_v2_x;
  assign face_w[2][1] = in_v2_y;
  assign face_w[2][2] = in_v2_z;

  // Occupancy counts every item in the term pipeline or the queue, so the
  // queue can never be written while full.
  assign in_stall = (occ_r == OW'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case ({accept, q_pop})
      2'b10:   occ_nxt = occ_r + 1'b1;
      2'b01:   occ_nxt = occ_r - 1'b1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  mvma_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (accept),
    .item_face (face_w),
    .item_last (in_last_triangle),
    .push      (push),
    .push_data (push_data)
  );

  mvma_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_data),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  mvma_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res_w)
  );

  assign out_vol_six   = res_w[IDX_VOL];
  assign out_first_x   = res_w[IDX_FIRST];
  assign out_first_y   = res_w[IDX_FIRST + 1];
  assign out_first_z   = res_w[IDX_FIRST + 2];
  assign out_second_xx = res_w[IDX_DIAG];
  assign out_second_yy = res_w[IDX_DIAG + 1];
  assign out_second_zz = res_w[IDX_DIAG + 2];
  assign out_second_xy = res_w[IDX_OFF];
  assign out_second_xz = res_w[IDX_OFF + 1];
  assign out_second_yz = res_w[IDX_OFF + 2];

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= OW'(QUEUE_DEPTH)) && !(q_pop && occ_r == '0))
    else $error("Occupancy count out of range.");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Mesh volume moment accumulator testbench
// Drives triangle streams into the accumulator and checks the ten saturating
// mesh sums on every last-triangle result. A scoreboard class keeps its own
// copy of the sums. Directed meshes cover degenerate and extreme triangles
// and open and closed meshes. Random closed tetrahedra, open meshes and
// triangle soup then run under several idle and stall mixes. A long output
// hold-off fills the block and forces it to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import mvma_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 198;
  localparam longint SUM_MAX = {1'b0, {63{1'b1}}};
  localparam longint SUM_MIN = {1'b1, 63'd0};

  typedef logic [NUM_AXES-1:0][FIELD_W-1:0] point_t;

  class moment_scoreboard;
    longint running[NUM_SUMS];
    res_t mesh_totals[$];
    int mismatches;
    int triangles;
    int meshes_checked;
    int saturated_adds;
    string field_names[NUM_SUMS] = '{"vol_six", "first_x", "first_y", "first_z",
      "second_xx", "second_yy", "second_zz", "second_xy", "second_xz", "second_yz"};

    function longint coord_value(logic [FIELD_W-1:0] raw);
      longint v;
      v = 0;
      for (int n = 0; n < COORD_W; n++) v[n] = raw[n];
      if (raw[COORD_W-1]) v = v - (longint'(1) <<< COORD_W);
      return v;
    endfunction

    function longint add_clamped(longint acc, longint term);
      longint wide_sum;
      wide_sum = acc + term;
      if (acc[63] == term[63] && wide_sum[63] != acc[63]) begin
        saturated_adds++;
        wide_sum = acc[63] ? SUM_MIN : SUM_MAX;
      end
      return wide_sum;
    endfunction

    function void note_triangle(face_t tri_in, logic last);
      longint p[3][3];
      longint s[3];
      longint terms[NUM_SUMS];
      longint d;
      longint q;
      longint t;
      int a;
      int b;
      res_t total;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) p[i][k] = coord_value(tri_in[i][k]);
      d = p[0][0] * (p[1][1] * p[2][2] - p[1][2] * p[2][1])
        - p[0][1] * (p[1][0] * p[2][2] - p[1][2] * p[2][0])
        + p[0][2] * (p[1][0] * p[2][1] - p[1][1] * p[2][0]);
      for (int k = 0; k < 3; k++) s[k] = p[0][k] + p[1][k] + p[2][k];
      terms[IDX_VOL] = d;
      for (int k = 0; k < 3; k++) begin
        q = p[0][k] * p[0][k] + p[1][k] * p[1][k] + p[2][k] * p[2][k]
          + p[0][k] * p[1][k] + p[0][k] * p[2][k] + p[1][k] * p[2][k];
        a = PAIR_A[k];
        b = PAIR_B[k];
        t = p[0][a] * p[0][b] + p[1][a] * p[1][b] + p[2][a] * p[2][b] + s[a] * s[b];
        terms[IDX_FIRST+k] = d * s[k];
        terms[IDX_DIAG+k] = d * q;
        terms[IDX_OFF+k] = d * t;
      end
      for (int n = 0; n < NUM_SUMS; n++) running[n] = add_clamped(running[n], terms[n]);
      triangles++;
      if (last) begin
        for (int n = 0; n < NUM_SUMS; n++) begin
          total[n] = running[n];
          running[n] = 0;
        end
        mesh_totals.push_back(total);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (mesh_totals.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with no mesh pending, vol_six actual %0d",
                 $time, $signed(got[IDX_VOL]));
        return;
      end
      want = mesh_totals.pop_front();
      meshes_checked++;
      for (int n = 0; n < NUM_SUMS; n++) begin
        if (got[n] !== want[n]) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t: %s expected %0d actual %0d", $time, field_names[n],
                     $signed(want[n]), $signed(got[n]));
        end
      end
    endfunction

    function int pending();
      return mesh_totals.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [FIELD_W-1:0] in_v0_x;
  logic signed [FIELD_W-1:0] in_v0_y;
  logic signed [FIELD_W-1:0] in_v0_z;
  logic signed [FIELD_W-1:0] in_v1_x;
  logic signed [FIELD_W-1:0] in_v1_y;
  logic signed [FIELD_W-1:0] in_v1_z;
  logic signed [FIELD_W-1:0] in_v2_x;
  logic signed [FIELD_W-1:0] in_v2_y;
  logic signed [FIELD_W-1:0] in_v2_z;
  logic in_last_triangle;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ACC_W-1:0] out_vol_six;
  logic signed [ACC_W-1:0] out_first_x;
  logic signed [ACC_W-1:0] out_first_y;
  logic signed [ACC_W-1:0] out_first_z;
  logic signed [ACC_W-1:0] out_second_xx;
  logic signed [ACC_W-1:0] out_second_yy;
  logic signed [ACC_W-1:0] out_second_zz;
  logic signed [ACC_W-1:0] out_second_xy;
  logic signed [ACC_W-1:0] out_second_xz;
  logic signed [ACC_W-1:0] out_second_yz;

  moment_scoreboard sb = new();
  face_t mesh_faces[$];
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  mesh_volume_moment_accumulator_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    face_t seen_face;
    res_t got;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        seen_face[0] = {in_v0_z, in_v0_y, in_v0_x};
        seen_face[1] = {in_v1_z, in_v1_y, in_v1_x};
        seen_face[2] = {in_v2_z, in_v2_y, in_v2_x};
        sb.note_triangle(seen_face, in_last_triangle);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        got[IDX_VOL] = out_vol_six;
        got[IDX_FIRST] = out_first_x;
        got[IDX_FIRST+1] = out_first_y;
        got[IDX_FIRST+2] = out_first_z;
        got[IDX_DIAG] = out_second_xx;
        got[IDX_DIAG+1] = out_second_yy;
        got[IDX_DIAG+2] = out_second_zz;
        got[IDX_OFF] = out_second_xy;
        got[IDX_OFF+1] = out_second_xz;
        got[IDX_OFF+2] = out_second_yz;
        sb.check_result(got);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic logic [FIELD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(FIELD_W-1){1'b0}}};
      1: return {1'b0, {(FIELD_W-1){1'b1}}};
      2: return FIELD_W'($urandom_range(16) - 8);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    for (int k = 0; k < NUM_AXES; k++) p[k] = rand_coord();
    return p;
  endfunction

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p[0] = FIELD_W'(x);
    p[1] = FIELD_W'(y);
    p[2] = FIELD_W'(z);
    return p;
  endfunction

  function automatic face_t make_face(point_t a, point_t b, point_t c);
    face_t f;
    f[0] = a;
    f[1] = b;
    f[2] = c;
    return f;
  endfunction

  task automatic add_tetra(input point_t a, input point_t b, input point_t c,
                           input point_t e, input int faces_kept);
    face_t faces[4];
    faces[0] = make_face(a, c, b);
    faces[1] = make_face(a, b, e);
    faces[2] = make_face(a, e, c);
    faces[3] = make_face(b, c, e);
    for (int i = 0; i < faces_kept; i++) mesh_faces.push_back(faces[i]);
  endtask

  task automatic send_triangle(input face_t f, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_v0_x <= f[0][0];
    in_v0_y <= f[0][1];
    in_v0_z <= f[0][2];
    in_v1_x <= f[1][0];
    in_v1_y <= f[1][1];
    in_v1_z <= f[1][2];
    in_v2_x <= f[2][0];
    in_v2_y <= f[2][1];
    in_v2_z <= f[2][2];
    in_last_triangle <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_mesh();
    for (int i = 0; i < mesh_faces.size(); i++)
      send_triangle(mesh_faces[i], i == mesh_faces.size() - 1);
    mesh_faces.delete();
  endtask

  task automatic run_random(input int n);
    int sent;
    int kind;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        repeat ($urandom_range(1, 2))
          add_tetra(rand_point(), rand_point(), rand_point(), rand_point(), 4);
      end else if (kind <= 7) begin
        add_tetra(rand_point(), rand_point(), rand_point(), rand_point(), 3);
      end else begin
        repeat ($urandom_range(1, 6))
          mesh_faces.push_back(make_face(rand_point(), rand_point(), rand_point()));
      end
      sent = sent + mesh_faces.size();
      send_mesh();
    end
  endtask

  initial begin
    face_t big_det;
    face_t big_det_flipped;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_v0_x = '0;
    in_v0_y = '0;
    in_v0_z = '0;
    in_v1_x = '0;
    in_v1_y = '0;
    in_v1_z = '0;
    in_v2_x = '0;
    in_v2_y = '0;
    in_v2_z = '0;
    in_last_triangle = 1'b0;
    big_det = make_face(pt(-512, -512, -512), pt(-512, 511, -512), pt(-512, -512, 511));
    big_det_flipped = make_face(big_det[0], big_det[2], big_det[1]);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first two meshes are degenerate and must give all zeros.
    mesh_faces.push_back(make_face(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0)));
    send_mesh();
    mesh_faces.push_back(make_face(pt(-512, -512, -512), pt(-512, -512, -512),
                                   pt(-512, -512, -512)));
    send_mesh();
    mesh_faces.push_back(big_det);
    send_mesh();
    mesh_faces.push_back(big_det_flipped);
    send_mesh();
    mesh_faces.push_back(make_face(pt(511, 0, 0), pt(0, 511, 0), pt(0, 0, 511)));
    send_mesh();
    add_tetra(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), 4);
    send_mesh();
    add_tetra(pt(511, -512, 511), pt(-512, 511, -512), pt(511, 511, -512),
              pt(-512, -512, 511), 2);
    send_mesh();
    repeat (3)
      mesh_faces.push_back(make_face(
        pt($urandom_range(1) ? 511 : -512, $urandom_range(1) ? 511 : -512,
           $urandom_range(1) ? 511 : -512),
        pt($urandom_range(1) ? 511 : -512, $urandom_range(1) ? 511 : -512,
           $urandom_range(1) ? 511 : -512),
        pt($urandom_range(1) ? 511 : -512, $urandom_range(1) ? 511 : -512,
           $urandom_range(1) ? 511 : -512)));
    send_mesh();

    run_random(RANDOM_PER_PHASE);
    idle_pct = 78;
    run_random(RANDOM_PER_PHASE);
    idle_pct = 0;
    stall_pct = 78;
    run_random(RANDOM_PER_PHASE);
    idle_pct = 9;
    stall_pct = 9;
    run_random(RANDOM_PER_PHASE);

    // The result side holds off while short meshes keep arriving back to back.
    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (30) begin
      repeat ($urandom_range(1, 2))
        mesh_faces.push_back(make_face(rand_point(), rand_point(), rand_point()));
      send_mesh();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d triangles and %0d checked mesh results,", sb.triangles,
             sb.meshes_checked);
    $display("with %0d clamped additions across idle, stall and hold-off phases.",
             sb.saturated_adds);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
